FILE: rtl/encoder_pwm_dimmer_control_macros.svh
// Assertion helpers for the dimmer control block.
// Builds that define SYNTH see empty bodies.
`ifndef ENCODER_PWM_DIMMER_CONTROL_MACROS_SVH
`define ENCODER_PWM_DIMMER_CONTROL_MACROS_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define EPDC_CHECK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("epdc: property violated");
// Check that the consequent holds in the cycle after the antecedent.
`define EPDC_CHECK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("epdc: sequence violated");
`else
`define EPDC_CHECK(label, clk, rst_n, prop)
`define EPDC_CHECK_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/epdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package epdc_pkg;

    localparam int LEVEL_W   = 7;
    localparam int CODE_W    = 8;
    localparam int CNT_W     = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODULE_ID        = 3'd0,
        CFG_DIMMABLE_LIGHT   = 3'd1,
        CFG_FIXED_LIGHT      = 3'd2,
        CFG_FIXED_FAN        = 3'd3,
        CFG_UPLOAD_PERIOD    = 3'd4,
        CFG_UPLOAD_ON_CHANGE = 3'd5,
        CFG_KNOB_STEP_LIMIT  = 3'd6
    } cfg_index_t;

    // Level step requests from the encoder decoder
    typedef struct packed {
        logic down;
        logic up;
    } knob_step_t;

endpackage

`default_nettype wire

FILE: rtl/encoder_pwm_dimmer_control.sv
`timescale 1ns / 1ps
`default_nettype none
// Dimmer control for a knob, a push button and a remote link, one transfer per 10 ms tick.
// Input stream (s_*): one transfer per tick carrying the encoder levels, the button
// event and an optional addressed remote command. Output stream (m_*): exactly one
// result transfer per input transfer with switch state, level, PWM compare value,
// timer enable, upload strobe, display strobe and the effective module code.
// The result is registered and valid in the cycle after the input transfer.
// Throughput: one transfer per cycle while the receiver keeps up; the tick logic is a
// short chain of compares, increments and muxes between the state and result registers.
// The block takes a new input while m_tready is high or the result register is empty,
// so a stalled receiver holds the pending result and blocks input only until it drains.
// Reset (aresetn low, synchronous) clears all tick state and the result valid, and
// loads the configuration defaults: module 1, dimmable 1, fixed light 0, fixed fan 2,
// upload period 20, periodic uploads, knob step limit 1.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr; write only while idle.

`include "encoder_pwm_dimmer_control_macros.svh"

module encoder_pwm_dimmer_control #(
    parameter int MAX_LEVEL = 100
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // config write port
    input  wire logic                               cfg_we,
    input  wire logic [epdc_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  wire logic [epdc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // input stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // tdata: knob_a[0], knob_b[1], button_press[2], remote_valid[3],
    //        remote_addr[11:4], remote_switch[12], remote_level[20:13], zero pad[23:21]
    input  wire logic [23:0]                        s_tdata,
    // result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // tdata: switch_on[0], level[7:1], compare_value[15:8], pwm_enable[16],
    //        upload_valid[17], display_changed[18], module_addr[26:19], zero pad[31:27]
    output logic [31:0]                             m_tdata
);

    localparam int TOP_I  = (MAX_LEVEL > 127) ? 127 : MAX_LEVEL;
    localparam int HALF_I = (TOP_I < 50) ? TOP_I : 50;
    localparam logic [epdc_pkg::LEVEL_W-1:0] TOP  = TOP_I[epdc_pkg::LEVEL_W-1:0];
    localparam logic [epdc_pkg::LEVEL_W-1:0] HALF = HALF_I[epdc_pkg::LEVEL_W-1:0];

    // unpack input fields
    logic       knob_a, knob_b, button_press, remote_valid, remote_switch;
    logic [7:0] remote_addr, remote_level;

    assign knob_a        = s_tdata[0];
    assign knob_b        = s_tdata[1];
    assign button_press  = s_tdata[2];
    assign remote_valid  = s_tdata[3];
    assign remote_addr   = s_tdata[11:4];
    assign remote_switch = s_tdata[12];
    assign remote_level  = s_tdata[20:13];

    // configuration registers
    logic [7:0] module_id_reg, dimmable_id_reg, fixed_light_id_reg, fixed_fan_id_reg;
    logic [7:0] upload_period_reg;
    logic       upload_on_change_reg;
    logic [3:0] knob_step_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            module_id_reg        <= 8'd1;
            dimmable_id_reg      <= 8'd1;
            fixed_light_id_reg   <= 8'd0;
            fixed_fan_id_reg     <= 8'd2;
            upload_period_reg    <= 8'd20;
            upload_on_change_reg <= 1'b0;
            knob_step_limit_reg  <= 4'd1;
        end else if (cfg_we) begin
            unique case (epdc_pkg::cfg_index_t'(cfg_addr))
                epdc_pkg::CFG_MODULE_ID:        module_id_reg        <= cfg_wdata;
                epdc_pkg::CFG_DIMMABLE_LIGHT:   dimmable_id_reg      <= cfg_wdata;
                epdc_pkg::CFG_FIXED_LIGHT:      fixed_light_id_reg   <= cfg_wdata;
                epdc_pkg::CFG_FIXED_FAN:        fixed_fan_id_reg     <= cfg_wdata;
                epdc_pkg::CFG_UPLOAD_PERIOD:    upload_period_reg    <= cfg_wdata;
                epdc_pkg::CFG_UPLOAD_ON_CHANGE: upload_on_change_reg <= cfg_wdata[0];
                epdc_pkg::CFG_KNOB_STEP_LIMIT:  knob_step_limit_reg  <= cfg_wdata[3:0];
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    // tick state
    logic       on_state_reg, on_state_next;
    logic [6:0] level_now_reg, level_now_next;
    logic       synced_switch_reg, synced_switch_next;
    logic [6:0] synced_level_reg, synced_level_next;
    logic       shown_switch_reg;
    logic [6:0] shown_level_reg;
    logic [7:0] tick_count_reg, tick_count_next;
    logic       timer_running_reg, timer_running_next;

    // result register
    logic       m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_tdata_reg, m_tdata_next;

    logic s_accept;
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // encoder detents only advance while the PWM timer runs
    epdc_pkg::knob_step_t knob_step;

    epdc_knob u_knob (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (s_accept && timer_running_reg),
        .knob_a     (knob_a),
        .knob_b     (knob_b),
        .step_limit (knob_step_limit_reg),
        .step       (knob_step)
    );

    // effective module code: unknown codes act as a dimmable light
    logic [7:0] module_eff;
    logic       fixed_kind, remote_hit;

    always_comb begin
        if (module_id_reg != dimmable_id_reg && module_id_reg != fixed_light_id_reg &&
            module_id_reg != fixed_fan_id_reg) begin
            module_eff = dimmable_id_reg;
        end else begin
            module_eff = module_id_reg;
        end
        fixed_kind = (module_eff == fixed_light_id_reg || module_eff == fixed_fan_id_reg) &&
                     (module_eff != dimmable_id_reg);
        remote_hit = remote_valid && (remote_addr == module_eff);
    end

    logic upload_strobe, display_strobe;

    always_comb begin
        on_state_next      = on_state_reg;
        level_now_next     = level_now_reg;
        synced_switch_next = synced_switch_reg;
        synced_level_next  = synced_level_reg;
        timer_running_next = timer_running_reg;
        tick_count_next    = tick_count_reg;
        upload_strobe      = 1'b0;

        // knob steps: down first, then up
        if (timer_running_reg) begin
            if (knob_step.down && level_now_next != 7'd0) level_now_next = level_now_next - 7'd1;
            if (knob_step.up && level_now_next < TOP)     level_now_next = level_now_next + 7'd1;
        end

        // addressed remote command, level saturated to the top
        if (remote_hit) begin
            on_state_next      = remote_switch;
            level_now_next     = (remote_level > {1'b0, TOP}) ? TOP : remote_level[6:0];
            synced_switch_next = remote_switch;
            synced_level_next  = level_now_next;
        end

        if (button_press) on_state_next = !on_state_next;

        // switch rules
        if (on_state_next && level_now_next == 7'd0) level_now_next = 7'd1;
        if (fixed_kind) level_now_next = on_state_next ? TOP : 7'd0;
        if (!on_state_next) level_now_next = 7'd0;

        // switch transition restarts the level and the timer
        if (synced_switch_next != on_state_next) begin
            synced_switch_next = on_state_next;
            timer_running_next = on_state_next;
            level_now_next     = on_state_next ? HALF : 7'd0;
        end

        // upload strobe: periodic count or change report
        if (!upload_on_change_reg) begin
            if (tick_count_reg < upload_period_reg) begin
                tick_count_next = tick_count_reg + 8'd1;
            end else begin
                tick_count_next = 8'd0;
                upload_strobe   = 1'b1;
            end
        end else if (synced_switch_next != on_state_next ||
                     synced_level_next != level_now_next) begin
            synced_switch_next = on_state_next;
            synced_level_next  = level_now_next;
            upload_strobe      = 1'b1;
        end

        display_strobe = (shown_switch_reg != on_state_next) ||
                         (shown_level_reg != level_now_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_state_reg      <= 1'b0;
            level_now_reg     <= '0;
            synced_switch_reg <= 1'b0;
            synced_level_reg  <= '0;
            shown_switch_reg  <= 1'b0;
            shown_level_reg   <= '0;
            tick_count_reg    <= '0;
            timer_running_reg <= 1'b0;
        end else if (s_accept) begin
            on_state_reg      <= on_state_next;
            level_now_reg     <= level_now_next;
            synced_switch_reg <= synced_switch_next;
            synced_level_reg  <= synced_level_next;
            shown_switch_reg  <= on_state_next;
            shown_level_reg   <= level_now_next;
            tick_count_reg    <= tick_count_next;
            timer_running_reg <= timer_running_next;
        end
    end

    // pack the result; compare value is level times two
    always_comb begin
        m_tdata_next        = '0;
        m_tdata_next[0]     = on_state_next;
        m_tdata_next[7:1]   = level_now_next;
        m_tdata_next[15:8]  = {level_now_next, 1'b0};
        m_tdata_next[16]    = timer_running_next;
        m_tdata_next[17]    = upload_strobe;
        m_tdata_next[18]    = display_strobe;
        m_tdata_next[26:19] = module_eff;
        m_tvalid_next       = s_accept || (m_tvalid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // hold the payload while the receiver stalls
    always_ff @(posedge aclk) begin
        if (s_accept) m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // an on state never reports level zero, an off state always does
    `EPDC_CHECK(a_on_nonzero, aclk, aresetn, (m_tvalid_reg && m_tdata_reg[0]) |-> (m_tdata_reg[7:1] != 7'd0))
    `EPDC_CHECK(a_off_zero, aclk, aresetn, (m_tvalid_reg && !m_tdata_reg[0]) |-> (m_tdata_reg[7:1] == 7'd0))
    // level stays within the top and the stored state matches the reported result
    `EPDC_CHECK(a_level_top, aclk, aresetn, m_tvalid_reg |-> (m_tdata_reg[7:1] <= TOP))
    `EPDC_CHECK_NEXT(a_state_match, aclk, aresetn, s_accept, (m_tdata_reg[7:1] == level_now_reg) && (m_tdata_reg[0] == on_state_reg))

endmodule

`default_nettype wire

FILE: rtl/epdc_knob.sv
`timescale 1ns / 1ps
`default_nettype none

module epdc_knob (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           step_en,
    input  wire logic                           knob_a,
    input  wire logic                           knob_b,
    input  wire logic [epdc_pkg::CNT_W-1:0]     step_limit,
    output epdc_pkg::knob_step_t                step
);

    logic                        moving_reg, moving_next;
    logic [epdc_pkg::CNT_W-1:0]  down_count_reg, down_count_next;
    logic [epdc_pkg::CNT_W-1:0]  up_count_reg, up_count_next;

    always_comb begin
        moving_next     = moving_reg;
        down_count_next = down_count_reg;
        up_count_next   = up_count_reg;
        step            = '0;
        // arm on equal levels, count one detent on the first mismatch
        if (knob_a == knob_b) begin
            moving_next = 1'b0;
        end else if (!moving_reg) begin
            moving_next = 1'b1;
            if (knob_a) begin
                if (down_count_reg < epdc_pkg::CNT_MAX) down_count_next = down_count_reg + 4'd1;
            end else begin
                if (up_count_reg < epdc_pkg::CNT_MAX) up_count_next = up_count_reg + 4'd1;
            end
        end
        if (down_count_next > step_limit) begin
            down_count_next = '0;
            step.down       = 1'b1;
        end
        if (up_count_next > step_limit) begin
            up_count_next = '0;
            step.up       = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            moving_reg     <= 1'b0;
            down_count_reg <= '0;
            up_count_reg   <= '0;
        end else if (step_en) begin
            moving_reg     <= moving_next;
            down_count_reg <= down_count_next;
            up_count_reg   <= up_count_next;
        end
    end

endmodule

`default_nettype wire
